// ----- rtl/crcfr_pkg.sv -----
// Shared constants, types and the CRC-8 byte update for the frame receiver.
package crcfr_pkg;

  localparam int WORDS_DEFAULT = 15;

  localparam logic [7:0] SYNC_FIRST_RESET  = 8'h58;
  localparam logic [7:0] SYNC_SECOND_RESET = 8'h50;
  localparam logic [7:0] CRC_POLY          = 8'h07;

  localparam int CFG_INDEX_W = 1;
  localparam logic [CFG_INDEX_W-1:0] CFG_SYNC_FIRST  = 1'b0;
  localparam logic [CFG_INDEX_W-1:0] CFG_SYNC_SECOND = 1'b1;

  // Write of one assembled payload word into the frame store.
  typedef struct packed {
    logic        en;
    logic        bank;
    logic [31:0] data;
  } word_wr_t;

  // Status of the frame token queue.
  typedef struct packed {
    logic full;
    logic empty;
    logic head;
  } queue_stat_t;

  // CRC-8, MSB first, no reflection, no final xor.
  function automatic logic [7:0] crc8_byte(input logic [7:0] crc, input logic [7:0] b);
    logic [7:0] c;
    c = crc ^ b;
    for (int i = 0; i < 8; i++) begin
      c = c[7] ? ((c << 1) ^ CRC_POLY) : (c << 1);
    end
    return c;
  endfunction

endpackage

// ----- rtl/crc8_frame_receiver.sv -----
// Top level of the CRC-8 sync-header frame receiver.
// Input channel (in_valid/in_ready, rx_byte) takes one received byte per request.
// The block hunts for sync_first then sync_second, collects WORDS little-endian
// 32-bit words (first byte in bits 7..0) and one check byte; the CRC-8 (poly
// 0x07, init 0, MSB first) covers header and payload. On a match the output
// channel (out_valid/out_ready) carries WORDS requests with word_index
// 0..WORDS-1 and last set on the final word; on a mismatch nothing comes out.
// Either way the receiver goes back to hunting.
// Throughput: the front end takes one byte per cycle while in_ready is high. The
// back end reads each word from the frame store with a registered memory read
// (FETCH), then shows it (SHOW); it fetches the next word only after the shown
// word is taken. A good frame's token enters the queue with the check byte.
// Stalls: two frame banks decouple the ends. When both hold frames not yet
// drained, in_ready drops at the payload or check byte until the back end frees
// one. A stall on out_ready holds the current word; header bytes still flow.
// Reset: rst (synchronous) returns to hunting, empties the token queue and
// loads sync_first = 0x58, sync_second = 0x50. cfg_write writes a sync byte into
// its register; it counts from the next header comparison.
module crc8_frame_receiver #(
  parameter int WORDS = crcfr_pkg::WORDS_DEFAULT
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  logic [7:0]                        rx_byte,
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic [3:0]                        word_index,
  output logic [31:0]                       word_value,
  output logic                              last,
  input  logic                              cfg_write,
  input  logic [crcfr_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  logic [7:0]                        cfg_data
);
  import crcfr_pkg::*;

  localparam int IW = (WORDS > 1) ? $clog2(WORDS) : 1;

  logic [7:0]    sync_first;
  logic [7:0]    sync_second;
  queue_stat_t   q_stat;
  logic          push;
  logic          push_bank;
  logic          pop;
  word_wr_t      wr;
  logic [IW-1:0] wr_word;

  // Hold the header bytes; unknown indexes cannot occur with a one-bit index.
  always_ff @(posedge clk) begin
    if (rst) begin
      sync_first  <= SYNC_FIRST_RESET;
      sync_second <= SYNC_SECOND_RESET;
    end else if (cfg_write) begin
      unique case (cfg_index)
        CFG_SYNC_FIRST:  sync_first  <= cfg_data;
        CFG_SYNC_SECOND: sync_second <= cfg_data;
        default: ;
      endcase
    end
  end

  // Front end: parse bytes, assemble words, judge the check byte.
  crcfr_front #(.WORDS(WORDS), .IW(IW)) u_front (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .rx_byte     (rx_byte),
    .sync_first  (sync_first),
    .sync_second (sync_second),
    .q_stat      (q_stat),
    .push        (push),
    .push_bank   (push_bank),
    .wr          (wr),
    .wr_word     (wr_word)
  );

  // Queue of good frames waiting to be drained.
  crcfr_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_bank (push_bank),
    .pop       (pop),
    .stat      (q_stat)
  );

  // Back end: frame store and word emitter.
  crcfr_back #(.WORDS(WORDS), .IW(IW)) u_back (
    .clk        (clk),
    .rst        (rst),
    .q_stat     (q_stat),
    .pop        (pop),
    .wr         (wr),
    .wr_word    (wr_word),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .word_index (word_index),
    .word_value (word_value),
    .last       (last)
  );

endmodule

// ----- rtl/crcfr_front.sv -----
// Front end: header hunt, payload assembly, running CRC and check-byte verdict.
module crcfr_front #(
  parameter int WORDS = crcfr_pkg::WORDS_DEFAULT,
  parameter int IW = (WORDS > 1) ? $clog2(WORDS) : 1
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   in_valid,
  output logic                   in_ready,
  input  logic [7:0]             rx_byte,
  input  logic [7:0]             sync_first,
  input  logic [7:0]             sync_second,
  input  crcfr_pkg::queue_stat_t q_stat,
  output logic                   push,
  output logic                   push_bank,
  output crcfr_pkg::word_wr_t    wr,
  output logic [IW-1:0]          wr_word
);
  import crcfr_pkg::*;

  typedef enum logic [1:0] {HUNT, SECOND, PAYLOAD, CHECK} phase_t;

  localparam logic [IW-1:0] LAST_WORD = IW'(WORDS - 1);

  phase_t        phase;
  logic [IW-1:0] word_cnt;
  logic [1:0]    lane;
  logic [7:0]    running_crc;
  logic [23:0]   partial;
  logic          bank;
  logic          take;

  // Stall payload and check bytes while both banks hold frames that wait for the back end.
  assign in_ready = !((phase == PAYLOAD || phase == CHECK) && q_stat.full);
  assign take     = in_valid && in_ready;

  assign wr.en     = take && phase == PAYLOAD && lane == 2'd3;
  assign wr.bank   = bank;
  assign wr.data   = {rx_byte, partial};
  assign wr_word   = word_cnt;
  assign push      = take && phase == CHECK && rx_byte == running_crc;
  assign push_bank = bank;

  always_ff @(posedge clk) begin
    if (rst) begin
      phase       <= HUNT;
      word_cnt    <= '0;
      lane        <= '0;
      running_crc <= '0;
      bank        <= 1'b0;
    end else if (take) begin
      unique case (phase)
        HUNT: begin
          if (rx_byte == sync_first) begin
            running_crc <= crc8_byte(8'h00, rx_byte);
            phase       <= SECOND;
          end
        end
        SECOND: begin
          if (rx_byte == sync_second) begin
            running_crc <= crc8_byte(running_crc, rx_byte);
            word_cnt    <= '0;
            lane        <= '0;
            phase       <= PAYLOAD;
          end else if (rx_byte == sync_first) begin
            running_crc <= crc8_byte(8'h00, rx_byte);
          end else begin
            running_crc <= '0;
            phase       <= HUNT;
          end
        end
        PAYLOAD: begin
          running_crc <= crc8_byte(running_crc, rx_byte);
          partial     <= {rx_byte, partial[23:8]};
          lane        <= lane + 2'd1;
          if (lane == 2'd3) begin
            word_cnt <= word_cnt + IW'(1);
            if (word_cnt == LAST_WORD) begin
              phase <= CHECK;
            end
          end
        end
        CHECK: begin
          if (rx_byte == running_crc) begin
            bank <= !bank;
          end
          running_crc <= '0;
          phase       <= HUNT;
        end
        default: phase <= HUNT;
      endcase
    end
  end

  a_no_push_when_full: assert property (@(posedge clk) disable iff (rst)
    push |-> !q_stat.full)
    else $error("frame token pushed into a full queue");

  a_no_write_on_pending: assert property (@(posedge clk) disable iff (rst)
    wr.en |-> !q_stat.full)
    else $error("payload written while both banks are pending");

endmodule

// ----- rtl/crcfr_queue.sv -----
// Two-entry queue of good-frame tokens, each naming the bank that holds the frame.
module crcfr_queue (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   push,
  input  logic                   push_bank,
  input  logic                   pop,
  output crcfr_pkg::queue_stat_t stat
);
  import crcfr_pkg::*;

  logic [1:0] slot;
  logic       rd_ptr;
  logic       wr_ptr;
  logic [1:0] count;

  assign stat.full  = count == 2'd2;
  assign stat.empty = count == 2'd0;
  assign stat.head  = slot[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      rd_ptr <= 1'b0;
      wr_ptr <= 1'b0;
      count  <= '0;
    end else begin
      if (push) begin
        slot[wr_ptr] <= push_bank;
        wr_ptr       <= !wr_ptr;
      end
      if (pop) begin
        rd_ptr <= !rd_ptr;
      end
      count <= count + {1'b0, push} - {1'b0, pop};
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    push && !pop |-> !stat.full)
    else $error("token queue overflow");

  a_no_underflow: assert property (@(posedge clk) disable iff (rst)
    pop |-> !stat.empty)
    else $error("token queue underflow");

endmodule

// ----- rtl/crcfr_back.sv -----
// Back end: two-bank frame store and the word emitter that drains a good frame.
module crcfr_back #(
  parameter int WORDS = crcfr_pkg::WORDS_DEFAULT,
  parameter int IW = (WORDS > 1) ? $clog2(WORDS) : 1
) (
  input  logic                   clk,
  input  logic                   rst,
  input  crcfr_pkg::queue_stat_t q_stat,
  output logic                   pop,
  input  crcfr_pkg::word_wr_t    wr,
  input  logic [IW-1:0]          wr_word,
  output logic                   out_valid,
  input  logic                   out_ready,
  output logic [3:0]             word_index,
  output logic [31:0]            word_value,
  output logic                   last
);
  import crcfr_pkg::*;

  localparam int DEPTH = 2 * WORDS;
  localparam int AW = $clog2(DEPTH);
  localparam logic [IW-1:0] LAST_WORD = IW'(WORDS - 1);
  localparam logic [AW-1:0] BANK_BASE = AW'(WORDS);

  typedef enum logic [1:0] {IDLE, FETCH, SHOW} state_t;

  logic [31:0]   mem [DEPTH];
  state_t        state;
  logic [IW-1:0] k;
  logic [31:0]   rd_data;
  logic [AW-1:0] wr_addr;
  logic [AW-1:0] rd_addr;

  assign wr_addr = AW'(wr_word) + (wr.bank ? BANK_BASE : '0);
  assign rd_addr = AW'(k) + (q_stat.head ? BANK_BASE : '0);

  assign out_valid  = state == SHOW;
  assign word_index = 4'(k);
  assign word_value = rd_data;
  assign last       = k == LAST_WORD;
  // Release the bank only once its last word has left.
  assign pop        = out_valid && out_ready && last;

  always_ff @(posedge clk) begin
    if (wr.en) begin
      mem[wr_addr] <= wr.data;
    end
    if (state == FETCH) begin
      rd_data <= mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= IDLE;
      k     <= '0;
    end else begin
      unique case (state)
        IDLE: begin
          if (!q_stat.empty) begin
            k     <= '0;
            state <= FETCH;
          end
        end
        FETCH: state <= SHOW;
        SHOW: begin
          if (out_ready) begin
            if (last) begin
              state <= IDLE;
            end else begin
              k     <= k + IW'(1);
              state <= FETCH;
            end
          end
        end
        default: state <= IDLE;
      endcase
    end
  end

  a_show_has_frame: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> !q_stat.empty)
    else $error("word shown with no frame pending");

  a_gap_after_word: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_ready && !last |=> !out_valid)
    else $error("next word shown before its fetch");

endmodule
